// ----- rtl/core/uart_rf_pkg.sv -----
// ----------------------------------------------------------------------------
// uart_rf_pkg
// Register map offsets, field widths and fixed status values for the
// 16550-style UART register front end.
// ----------------------------------------------------------------------------
package uart_rf_pkg;

    localparam int OFFSET_W     = 12;
    localparam int DATA_W       = 8;
    localparam int WINDOW_BYTES = 4096;

    // access codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register offsets
    localparam logic [OFFSET_W-1:0] OFS_THR   = 12'h000;
    localparam logic [OFFSET_W-1:0] OFS_IER   = 12'h004;
    localparam logic [OFFSET_W-1:0] OFS_FCR   = 12'h008;
    localparam logic [OFFSET_W-1:0] OFS_LCR   = 12'h00C;
    localparam logic [OFFSET_W-1:0] OFS_MCR   = 12'h010;
    localparam logic [OFFSET_W-1:0] OFS_LSR   = 12'h014;
    localparam logic [OFFSET_W-1:0] OFS_MSR   = 12'h018;
    localparam logic [OFFSET_W-1:0] OFS_SPR   = 12'h01C;
    localparam logic [OFFSET_W-1:0] OFS_MDR1  = 12'h020;
    localparam logic [OFFSET_W-1:0] OFS_TXFLL = 12'h028;
    localparam logic [OFFSET_W-1:0] OFS_RXFLL = 12'h02C;
    localparam logic [OFFSET_W-1:0] OFS_TXFLH = 12'h030;
    localparam logic [OFFSET_W-1:0] OFS_SCR   = 12'h040;
    localparam logic [OFFSET_W-1:0] OFS_SSR   = 12'h044;
    localparam logic [OFFSET_W-1:0] OFS_SYSC  = 12'h054;
    localparam logic [OFFSET_W-1:0] OFS_SYSS  = 12'h058;
    localparam logic [OFFSET_W-1:0] OFS_WER   = 12'h05C;

    // fixed read values and bit positions
    localparam logic [DATA_W-1:0] LSR_TX_READY  = 8'h60;
    localparam logic [DATA_W-1:0] IIR_NO_INT    = 8'h01;
    localparam logic [DATA_W-1:0] SYSS_RST_DONE = 8'h01;
    localparam logic [DATA_W-1:0] SSR_IDLE      = 8'h00;
    localparam logic [DATA_W-1:0] SYSC_RST_BIT  = 8'h02;
    localparam int                LCR_DLAB_BIT  = 7;
    localparam int                SCR_DMA_BIT   = 0;
    localparam int                FCR_EN_BIT    = 0;
    localparam int                FCR_DMA_BIT   = 3;

endpackage

// ----- rtl/core/uart_register_file_model_core.sv -----
// ----------------------------------------------------------------------------
// uart_register_file_model_core
// Register front end of a 16550-style UART: decodes byte reads and writes,
// banks the divisor latch, returns fixed status and raises tx dma requests.
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless out_ready stalls a held result; the
//   decode and register update of an item complete at its acceptance edge,
//   so the next item sees the new state and the result register is loaded
// reset: all control registers and result valid clear to zero asynchronously
// ----------------------------------------------------------------------------
module uart_register_file_model_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic [uart_rf_pkg::OFFSET_W-1:0] offset,
    input  logic [uart_rf_pkg::DATA_W-1:0]   write_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [uart_rf_pkg::DATA_W-1:0]   read_data,
    output logic                             tx_valid,
    output logic [uart_rf_pkg::DATA_W-1:0]   tx_byte,
    output logic                             tx_dma_request,
    output logic                             access_error
);
    import uart_rf_pkg::*;

    logic [DATA_W-1:0] ier_reg,  ier_next;
    logic [DATA_W-1:0] fcr_reg,  fcr_next;
    logic [DATA_W-1:0] lcr_reg,  lcr_next;
    logic [DATA_W-1:0] mcr_reg,  mcr_next;
    logic [DATA_W-1:0] mdr1_reg, mdr1_next;
    logic [DATA_W-1:0] scr_reg,  scr_next;
    logic [DATA_W-1:0] msr_reg,  msr_next;
    logic [DATA_W-1:0] spr_reg,  spr_next;
    logic [DATA_W-1:0] dll_reg,  dll_next;
    logic [DATA_W-1:0] dlh_reg,  dlh_next;
    logic [DATA_W-1:0] sysc_reg, sysc_next;
    logic [DATA_W-1:0] wer_reg,  wer_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] rd_reg,  rd_next;
    logic              txv_reg, txv_next;
    logic [DATA_W-1:0] txb_reg, txb_next;
    logic              dma_reg, dma_next;
    logic              err_reg, err_next;

    logic accept;
    logic dlab;
    logic in_window;

    function automatic logic dma_active(input logic [DATA_W-1:0] fcr,
                                        input logic [DATA_W-1:0] scr);
        logic result;
        if (scr[SCR_DMA_BIT])
        begin
            // mode bits 2:1 equal to 1 or 3
            result = scr[1];
        end
        else
        begin
            result = fcr[FCR_EN_BIT] & fcr[FCR_DMA_BIT];
        end
        return result;
    endfunction

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign dlab      = lcr_reg[LCR_DLAB_BIT];
    assign in_window = 32'(offset) < WINDOW_BYTES;

    always_comb
    begin
        ier_next  = ier_reg;
        fcr_next  = fcr_reg;
        lcr_next  = lcr_reg;
        mcr_next  = mcr_reg;
        mdr1_next = mdr1_reg;
        scr_next  = scr_reg;
        msr_next  = msr_reg;
        spr_next  = spr_reg;
        dll_next  = dll_reg;
        dlh_next  = dlh_reg;
        sysc_next = sysc_reg;
        wer_next  = wer_reg;
        rd_next   = '0;
        txv_next  = 1'b0;
        txb_next  = '0;
        dma_next  = 1'b0;
        err_next  = 1'b0;

        if (!in_window)
        begin
            err_next = 1'b1;
        end
        else if (operation == OP_READ)
        begin
            case (offset)
                OFS_THR:   rd_next = dlab ? dll_reg : '0;
                OFS_IER:   rd_next = dlab ? dlh_reg : ier_reg;
                OFS_FCR:   rd_next = IIR_NO_INT;
                OFS_LCR:   rd_next = lcr_reg;
                OFS_MCR:   rd_next = mcr_reg;
                OFS_LSR:   rd_next = LSR_TX_READY;
                OFS_MSR:   rd_next = msr_reg;
                OFS_SPR:   rd_next = spr_reg;
                OFS_MDR1:  rd_next = mdr1_reg;
                OFS_TXFLL, OFS_RXFLL, OFS_TXFLH: rd_next = '0;
                OFS_SCR:   rd_next = scr_reg;
                OFS_SSR:   rd_next = SSR_IDLE;
                OFS_SYSC:  rd_next = sysc_reg;
                OFS_SYSS:  rd_next = SYSS_RST_DONE;
                OFS_WER:   rd_next = wer_reg;
                default:   err_next = 1'b1;
            endcase
        end
        else
        begin
            case (offset)
                OFS_THR:
                begin
                    if (dlab)
                    begin
                        dll_next = write_data;
                    end
                    else
                    begin
                        txv_next = 1'b1;
                        txb_next = write_data;
                        dma_next = dma_active(fcr_reg, scr_reg);
                    end
                end
                OFS_IER:
                begin
                    if (dlab)
                    begin
                        dlh_next = write_data;
                    end
                    else
                    begin
                        ier_next = write_data;
                    end
                end
                OFS_FCR:
                begin
                    fcr_next = write_data;
                    dma_next = dma_active(write_data, scr_reg);
                end
                OFS_LCR:  lcr_next  = write_data;
                OFS_MCR:  mcr_next  = write_data;
                OFS_MSR:  msr_next  = write_data;
                OFS_SPR:  spr_next  = write_data;
                OFS_MDR1: mdr1_next = write_data;
                OFS_SCR:
                begin
                    scr_next = write_data;
                    dma_next = dma_active(fcr_reg, write_data);
                end
                // soft reset bit self-clears
                OFS_SYSC: sysc_next = write_data & ~SYSC_RST_BIT;
                OFS_WER:  wer_next  = write_data;
                OFS_LSR, OFS_TXFLL, OFS_RXFLL, OFS_TXFLH, OFS_SSR, OFS_SYSS: ;
                default:  err_next  = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ier_reg       <= '0;
            fcr_reg       <= '0;
            lcr_reg       <= '0;
            mcr_reg       <= '0;
            mdr1_reg      <= '0;
            scr_reg       <= '0;
            msr_reg       <= '0;
            spr_reg       <= '0;
            dll_reg       <= '0;
            dlh_reg       <= '0;
            sysc_reg      <= '0;
            wer_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ier_reg  <= ier_next;
                fcr_reg  <= fcr_next;
                lcr_reg  <= lcr_next;
                mcr_reg  <= mcr_next;
                mdr1_reg <= mdr1_next;
                scr_reg  <= scr_next;
                msr_reg  <= msr_next;
                spr_reg  <= spr_next;
                dll_reg  <= dll_next;
                dlh_reg  <= dlh_next;
                sysc_reg <= sysc_next;
                wer_reg  <= wer_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg  <= rd_next;
            txv_reg <= txv_next;
            txb_reg <= txb_next;
            dma_reg <= dma_next;
            err_reg <= err_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = rd_reg;
    assign tx_valid       = txv_reg;
    assign tx_byte        = txb_reg;
    assign tx_dma_request = dma_reg;
    assign access_error   = err_reg;

    // an error result carries nothing else
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && access_error |->
            read_data == '0 && !tx_valid && tx_byte == '0 && !tx_dma_request)
        else $error("error result with nonzero payload");

    // a transmit byte only comes from a write, never with read data
    a_tx_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_valid |-> read_data == '0 && !access_error)
        else $error("transmit item carries read data");

    a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == '0)
        else $error("tx byte set without tx valid");

    // soft reset bit never stays set
    a_sysc_rst: assert property (@(posedge clk) disable iff (!rst_n)
        (sysc_reg & SYSC_RST_BIT) == '0)
        else $error("soft reset bit stored");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte reads and writes at register offsets into the uart register
// front end and checks each reply against its table reply or a cycle-free register predictor.
// A short table of directed accesses comes first, then random traffic in
// phases with and without idling on either side.
// ----------------------------------------------------------------------------
module testbench;

    import uart_rf_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 488;   // per idling phase, four phases

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              tx_valid;
        logic [DATA_W-1:0] tx_byte;
        logic              tx_dma_request;
        logic              access_error;
    } reply_t;

    typedef struct {
        logic                op;
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   wd;
        bit                  known;
        reply_t              literal;
    } access_row_t;

    logic                clk;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic                operation      = OP_READ;
    logic [OFFSET_W-1:0] offset         = '0;
    logic [DATA_W-1:0]   write_data     = '0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [DATA_W-1:0]   read_data;
    logic                tx_valid;
    logic [DATA_W-1:0]   tx_byte;
    logic                tx_dma_request;
    logic                access_error;

    // travels with the item: reply typed into the table, if any
    bit                  item_known     = 1'b0;
    reply_t              item_literal   = '0;

    // register copies of the predictor
    logic [DATA_W-1:0]   ier_q, fcr_q, lcr_q, mcr_q, mdr1_q, scr_q;
    logic [DATA_W-1:0]   msr_q, spr_q, dll_q, dlh_q, sysc_q, wer_q;

    reply_t              pending_replies[$];
    access_row_t         directed_rows[$];
    logic [OFFSET_W-1:0] defined_offsets [0:16];
    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count    = 0;

    uart_register_file_model_core u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .offset         (offset),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .tx_valid       (tx_valid),
        .tx_byte        (tx_byte),
        .tx_dma_request (tx_dma_request),
        .access_error   (access_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic tx_dma_on();
        // scr dma control overrides the fcr dma mode; scr modes 1 and 3 drive tx
        if (scr_q[SCR_DMA_BIT])
            return scr_q[2:1] == 2'd1 || scr_q[2:1] == 2'd3;
        else
            return fcr_q[FCR_EN_BIT] && fcr_q[FCR_DMA_BIT];
    endfunction

    function automatic reply_t predict_access(input logic op,
                                              input logic [OFFSET_W-1:0] off,
                                              input logic [DATA_W-1:0] wd);
        reply_t r;
        logic   dlab;
        bit     hit;
        r    = '0;
        dlab = lcr_q[LCR_DLAB_BIT];
        hit  = int'(off) < WINDOW_BYTES;
        if (hit && op == OP_READ)
        begin
            case (off)
                OFS_THR:   r.read_data = dlab ? dll_q : 8'h00;
                OFS_IER:   r.read_data = dlab ? dlh_q : ier_q;
                OFS_FCR:   r.read_data = IIR_NO_INT;
                OFS_LCR:   r.read_data = lcr_q;
                OFS_MCR:   r.read_data = mcr_q;
                OFS_LSR:   r.read_data = LSR_TX_READY;
                OFS_MSR:   r.read_data = msr_q;
                OFS_SPR:   r.read_data = spr_q;
                OFS_MDR1:  r.read_data = mdr1_q;
                OFS_TXFLL, OFS_RXFLL, OFS_TXFLH:
                           r.read_data = 8'h00;
                OFS_SCR:   r.read_data = scr_q;
                OFS_SSR:   r.read_data = SSR_IDLE;
                OFS_SYSC:  r.read_data = sysc_q;
                OFS_SYSS:  r.read_data = SYSS_RST_DONE;
                OFS_WER:   r.read_data = wer_q;
                default:   hit = 1'b0;
            endcase
        end
        else if (hit)
        begin
            case (off)
                OFS_THR:
                    if (dlab)
                        dll_q = wd;
                    else
                    begin
                        r.tx_valid       = 1'b1;
                        r.tx_byte        = wd;
                        r.tx_dma_request = tx_dma_on();
                    end
                OFS_IER:
                    if (dlab)
                        dlh_q = wd;
                    else
                        ier_q = wd;
                OFS_FCR:
                begin
                    fcr_q            = wd;
                    r.tx_dma_request = tx_dma_on();
                end
                OFS_LCR:   lcr_q  = wd;
                OFS_MCR:   mcr_q  = wd;
                OFS_MSR:   msr_q  = wd;
                OFS_SPR:   spr_q  = wd;
                OFS_MDR1:  mdr1_q = wd;
                OFS_SCR:
                begin
                    scr_q            = wd;
                    r.tx_dma_request = tx_dma_on();
                end
                OFS_SYSC:  sysc_q = wd & ~SYSC_RST_BIT;
                OFS_WER:   wer_q  = wd;
                OFS_LSR, OFS_TXFLL, OFS_RXFLL, OFS_TXFLH, OFS_SSR, OFS_SYSS:
                begin
                end
                default:   hit = 1'b0;
            endcase
        end
        if (!hit)
        begin
            r              = '0;
            r.access_error = 1'b1;
        end
        return r;
    endfunction

    function automatic void add_row(input logic op, input logic [OFFSET_W-1:0] off,
                                    input logic [DATA_W-1:0] wd, input bit known,
                                    input logic [DATA_W-1:0] rd, input logic txv,
                                    input logic [DATA_W-1:0] txb, input logic dma,
                                    input logic err);
        access_row_t row;
        row.op      = op;
        row.off     = off;
        row.wd      = wd;
        row.known   = known;
        row.literal = {rd, txv, txb, dma, err};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic drive_access(input logic op, input logic [OFFSET_W-1:0] off,
                                input logic [DATA_W-1:0] wd, input bit known,
                                input reply_t literal);
        int unsigned gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct && gap < 30)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        offset       <= off;
        write_data   <= wd;
        item_known   <= known;
        item_literal <= literal;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // receiver side stalls
    always @(posedge clk)
        out_ready <= $urandom_range(0, 99) >= recv_stall_pct;

    // predicts on acceptance, then checks the reply taken at the same edge
    always @(posedge clk)
    begin : reply_check
        reply_t got;
        reply_t want;
        reply_t pred;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d replies outstanding", $time,
                     pending_replies.size());
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pred = predict_access(operation, offset, write_data);
                pending_replies.insert(pending_replies.size(),
                                       item_known ? item_literal : pred);
            end
            if (out_valid && out_ready)
            begin
                got = {read_data, tx_valid, tx_byte, tx_dma_request, access_error};
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply, expected none, actual %h",
                             $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, got.read_data);
                        mismatch_count++;
                    end
                    if (got.tx_valid !== want.tx_valid)
                    begin
                        $display("%0t: tx_valid expected %b actual %b",
                                 $time, want.tx_valid, got.tx_valid);
                        mismatch_count++;
                    end
                    if (got.tx_byte !== want.tx_byte)
                    begin
                        $display("%0t: tx_byte expected %h actual %h",
                                 $time, want.tx_byte, got.tx_byte);
                        mismatch_count++;
                    end
                    if (got.tx_dma_request !== want.tx_dma_request)
                    begin
                        $display("%0t: tx_dma_request expected %b actual %b",
                                 $time, want.tx_dma_request, got.tx_dma_request);
                        mismatch_count++;
                    end
                    if (got.access_error !== want.access_error)
                    begin
                        $display("%0t: access_error expected %b actual %b",
                                 $time, want.access_error, got.access_error);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned sel;
        logic        op;
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   wd;

        {ier_q, fcr_q, lcr_q, mcr_q, mdr1_q, scr_q} = '0;
        {msr_q, spr_q, dll_q, dlh_q, sysc_q, wer_q} = '0;
        defined_offsets = '{OFS_THR, OFS_IER, OFS_FCR, OFS_LCR, OFS_MCR, OFS_LSR,
                            OFS_MSR, OFS_SPR, OFS_MDR1, OFS_TXFLL, OFS_RXFLL,
                            OFS_TXFLH, OFS_SCR, OFS_SSR, OFS_SYSC, OFS_SYSS, OFS_WER};

        // status values after reset, errors, extremes
        add_row(OP_READ,  OFS_LSR,  8'h00, 1'b1, 8'h60, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_READ,  OFS_FCR,  8'hFF, 1'b1, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_READ,  OFS_SYSS, 8'h00, 1'b1, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_READ,  OFS_SSR,  8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        // receive data reads zero with the latch bit clear
        add_row(OP_READ,  OFS_THR,  8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_READ,  12'hFFF,  8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
        add_row(OP_WRITE, 12'hFFF,  8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
        add_row(OP_READ,  12'h024,  8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
        add_row(OP_WRITE, 12'h001,  8'h5A, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
        add_row(OP_WRITE, OFS_THR,  8'hFF, 1'b1, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0);
        add_row(OP_WRITE, OFS_THR,  8'h00, 1'b1, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
        // read-only registers swallow writes
        add_row(OP_WRITE, OFS_LSR,  8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_WRITE, OFS_SYSS, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_WRITE, OFS_TXFLH, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_READ,  OFS_SYSS, 8'h00, 1'b1, 8'h01, 1'b0, 8'h00, 1'b0, 1'b0);
        // soft reset bit never sticks
        add_row(OP_WRITE, OFS_SYSC, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_READ,  OFS_SYSC, 8'h00, 1'b1, 8'hFD, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_WRITE, OFS_FCR,  8'h09, 1'b1, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
        add_row(OP_WRITE, OFS_THR,  8'hA5, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_WRITE, OFS_SCR,  8'h03, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_WRITE, OFS_SCR,  8'h05, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_WRITE, OFS_SCR,  8'h07, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        // divisor latch banking
        add_row(OP_WRITE, OFS_LCR,  8'h80, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_WRITE, OFS_THR,  8'h34, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_WRITE, OFS_IER,  8'h12, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_READ,  OFS_THR,  8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(OP_READ,  OFS_IER,  8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_access(directed_rows[i].op, directed_rows[i].off, directed_rows[i].wd,
                         directed_rows[i].known, directed_rows[i].literal);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                op  = 1'($urandom_range(0, 1));
                wd  = DATA_W'($urandom);
                if (sel < 8)
                    off = OFFSET_W'($urandom);            // anywhere in the window
                else if (sel < 14)
                    off = OFFSET_W'($urandom_range(0, 127)); // gaps and misaligned
                else if (sel < 30)
                    off = $urandom_range(0, 1) ? OFS_IER : OFS_THR;
                else if (sel < 40)
                begin
                    op  = OP_WRITE;                       // flip the latch bit often
                    off = OFS_LCR;
                end
                else if (sel < 55)
                    off = $urandom_range(0, 1) ? OFS_SCR : OFS_FCR;
                else
                    off = defined_offsets[$urandom_range(0, 16)];
                drive_access(op, off, wd, 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        // let the last accepted item reach the reply queue first
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
